// ===== src/assert_macros.svh =====
// Assertion helpers used by the checker file spq_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, idle while reset is held.
`define SPQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("spq check failed: same-cycle implication");

// Next-cycle implication, idle while reset is held.
`define SPQ_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("spq check failed: next-cycle implication");

`endif

// ===== src/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH_DEF         = 16;
  localparam int TAG_BITS_DEF      = 16;
  localparam int PRIORITY_BITS_DEF = 8;

  localparam int STATUS_BITS = 2;

  // Command codes
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Per-cycle operation broadcast to every cell
  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctl_t;

endpackage

// ===== src/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept sorted in a chain of slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one command per transfer:
//   enqueue a tag with a priority, or dequeue the front entry. Larger
//   priorities leave first; equal priorities leave in order of arrival.
//   Result channel (out_valid / out_stall) returns exactly one result per
//   command: status, the removed tag and priority (zero unless a dequeue
//   succeeded) and the occupancy after the command.
//   The result is registered and shows in the cycle after the input
//   transfer. Throughput: one command per cycle while the result channel
//   does not stall; every cell decides its own next entry from its neighbours
//   in the same cycle, so the chain of compare-and-shift cells sets the pace.
//   A full queue drops an enqueue and reports full; an empty queue reports
//   empty on a dequeue. Neither changes the stored entries.
//   Reset empties the queue at once (only the entry count and out_valid are cleared).
//   When the receiver stalls, the result register holds and in_stall rises
//   until it drains, so no command is taken without room for its result.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
  parameter int DEPTH         = spq_pkg::DEPTH_DEF,
  parameter int TAG_BITS      = spq_pkg::TAG_BITS_DEF,
  parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
  localparam int OCC_BITS     = $clog2(DEPTH + 1)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_command,
  input  logic [TAG_BITS-1:0]             in_entry_tag,
  input  logic [PRIORITY_BITS-1:0]        in_entry_priority,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [spq_pkg::STATUS_BITS-1:0] out_status,
  output logic [TAG_BITS-1:0]             out_removed_tag,
  output logic [PRIORITY_BITS-1:0]        out_removed_priority,
  output logic [OCC_BITS-1:0]             out_occupancy
);

  // Cell outputs, indexed from the front (served first) to the back
  logic [TAG_BITS-1:0]      cell_tag  [DEPTH];
  logic [PRIORITY_BITS-1:0] cell_prio [DEPTH];
  logic                     cell_ge   [DEPTH];

  spq_pkg::cell_ctl_t ctl;

  logic [OCC_BITS-1:0] count_r, count_nxt;
  logic                out_valid_r, out_valid_nxt;

  spq_pkg::status_t         status_r,   status_nxt;
  logic [TAG_BITS-1:0]      rm_tag_r,   rm_tag_nxt;
  logic [PRIORITY_BITS-1:0] rm_prio_r,  rm_prio_nxt;
  logic [OCC_BITS-1:0]      occ_out_r,  occ_out_nxt;

  logic accept;
  logic is_deq;
  logic empty;
  logic full;

  // Take a command only when the result register is free or draining
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign is_deq = (in_command == spq_pkg::CMD_DEQ);
  assign empty  = (count_r == '0);
  assign full   = (count_r == OCC_BITS'(DEPTH));

  // Broadcast the operation to the chain; rejected commands leave it alone
  assign ctl.enq = accept && !is_deq && !full;
  assign ctl.deq = accept &&  is_deq && !empty;

  // ---- Cell chain ----------------------------------------------------------
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic                     left_ge;
    logic [TAG_BITS-1:0]      left_tag;
    logic [PRIORITY_BITS-1:0] left_prio;
    logic [TAG_BITS-1:0]      right_tag;
    logic [PRIORITY_BITS-1:0] right_prio;

    if (g == 0) begin : g_front
      // Front cell: nothing ahead, so a newcomer that beats this entry lands here
      assign left_ge   = 1'b1;
      assign left_tag  = in_entry_tag;
      assign left_prio = in_entry_priority;
    end else begin : g_inner
      assign left_ge   = cell_ge[g-1];
      assign left_tag  = cell_tag[g-1];
      assign left_prio = cell_prio[g-1];
    end

    if (g == DEPTH - 1) begin : g_back
      // Back cell: keep its own entry on a dequeue, it falls beyond the count
      assign right_tag  = cell_tag[g];
      assign right_prio = cell_prio[g];
    end else begin : g_mid
      assign right_tag  = cell_tag[g+1];
      assign right_prio = cell_prio[g+1];
    end

    spq_cell #(
      .TAG_BITS      (TAG_BITS),
      .PRIORITY_BITS (PRIORITY_BITS)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .new_tag    (in_entry_tag),
      .new_prio   (in_entry_priority),
      .occ        (count_r > OCC_BITS'(g)),
      .left_ge    (left_ge),
      .left_tag   (left_tag),
      .left_prio  (left_prio),
      .right_tag  (right_tag),
      .right_prio (right_prio),
      .tag        (cell_tag[g]),
      .prio       (cell_prio[g]),
      .ge         (cell_ge[g])
    );
  end

  // ---- Count and result ----------------------------------------------------
  always_comb begin
    count_nxt   = count_r;
    status_nxt  = status_r;
    rm_tag_nxt  = rm_tag_r;
    rm_prio_nxt = rm_prio_r;
    occ_out_nxt = occ_out_r;
    if (accept) begin
      status_nxt  = spq_pkg::ST_DONE;
      rm_tag_nxt  = '0;
      rm_prio_nxt = '0;
      priority if (ctl.deq) begin
        // Hand out the front entry
        count_nxt   = count_r - OCC_BITS'(1);
        rm_tag_nxt  = cell_tag[0];
        rm_prio_nxt = cell_prio[0];
      end else if (ctl.enq) begin
        count_nxt = count_r + OCC_BITS'(1);
      end else if (is_deq) begin
        status_nxt = spq_pkg::ST_EMPTY;
      end else begin
        // Drop the entry, no room
        status_nxt = spq_pkg::ST_FULL;
      end
      occ_out_nxt = count_nxt;
    end
  end

  assign out_valid_nxt = accept || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    rm_tag_r  <= rm_tag_nxt;
    rm_prio_r <= rm_prio_nxt;
    occ_out_r <= occ_out_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_status           = status_r;
  assign out_removed_tag      = rm_tag_r;
  assign out_removed_priority = rm_prio_r;
  assign out_occupancy        = occ_out_r;

endmodule

// ===== src/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, shifts or inserts on enqueue or dequeue.
// ----------------------------------------------------------------------------
module spq_cell #(
  parameter int TAG_BITS      = spq_pkg::TAG_BITS_DEF,
  parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF
) (
  input  logic                     clk,
  input  spq_pkg::cell_ctl_t       ctl,
  input  logic [TAG_BITS-1:0]      new_tag,
  input  logic [PRIORITY_BITS-1:0] new_prio,
  input  logic                     occ,
  input  logic                     left_ge,
  input  logic [TAG_BITS-1:0]      left_tag,
  input  logic [PRIORITY_BITS-1:0] left_prio,
  input  logic [TAG_BITS-1:0]      right_tag,
  input  logic [PRIORITY_BITS-1:0] right_prio,
  output logic [TAG_BITS-1:0]      tag,
  output logic [PRIORITY_BITS-1:0] prio,
  output logic                     ge
);

  logic [TAG_BITS-1:0]      tag_r,  tag_nxt;
  logic [PRIORITY_BITS-1:0] prio_r, prio_nxt;

  // Entry stays ahead of the newcomer when equal or higher
  assign ge = occ && (prio_r >= new_prio);

  always_comb begin
    tag_nxt  = tag_r;
    prio_nxt = prio_r;
    if (ctl.enq) begin
      if (!ge) begin
        if (left_ge) begin
          tag_nxt  = new_tag;
          prio_nxt = new_prio;
        end else begin
          tag_nxt  = left_tag;
          prio_nxt = left_prio;
        end
      end
    end else if (ctl.deq) begin
      tag_nxt  = right_tag;
      prio_nxt = right_prio;
    end
  end

  always_ff @(posedge clk) begin
    tag_r  <= tag_nxt;
    prio_r <= prio_nxt;
  end

  assign tag  = tag_r;
  assign prio = prio_r;

endmodule

// ===== src/spq_checker.sv =====
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks of the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spq_checker #(
  parameter int DEPTH         = spq_pkg::DEPTH_DEF,
  parameter int TAG_BITS      = spq_pkg::TAG_BITS_DEF,
  parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
  localparam int OCC_BITS     = $clog2(DEPTH + 1)
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [spq_pkg::STATUS_BITS-1:0] out_status,
  input logic [TAG_BITS-1:0]             out_removed_tag,
  input logic [PRIORITY_BITS-1:0]        out_removed_priority,
  input logic [OCC_BITS-1:0]             out_occupancy
);

  logic in_xfer;
  logic is_empty_st;
  logic is_full_st;
  logic empty_clean;
  logic stalled;

  assign in_xfer     = in_valid && !in_stall;
  assign is_empty_st = (out_status == spq_pkg::ST_EMPTY);
  assign is_full_st  = (out_status == spq_pkg::ST_FULL);
  assign empty_clean = (out_occupancy == '0) && (out_removed_tag == '0) &&
                       (out_removed_priority == '0);
  assign stalled     = out_valid && out_stall;

  // Every command transfer yields a result in the next cycle
  `SPQ_ASSERT_NXT(a_result_follows, clk, rst_n, in_xfer, out_valid)

  // Empty report only with nothing held, and nothing removed
  `SPQ_ASSERT_IMP(a_empty_consistent, clk, rst_n, out_valid && is_empty_st, empty_clean)

  // Full report only with every slot held
  `SPQ_ASSERT_IMP(a_full_consistent, clk, rst_n, out_valid && is_full_st, out_occupancy == OCC_BITS'(DEPTH))

  // A stalled result holds its status
  `SPQ_ASSERT_NXT(a_stall_holds, clk, rst_n, stalled, out_valid && $stable({out_status, out_occupancy}))

endmodule

bind sorted_priority_queue spq_checker #(
  .DEPTH         (DEPTH),
  .TAG_BITS      (TAG_BITS),
  .PRIORITY_BITS (PRIORITY_BITS)
) u_spq_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_stall             (in_stall),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_status           (out_status),
  .out_removed_tag      (out_removed_tag),
  .out_removed_priority (out_removed_priority),
  .out_occupancy        (out_occupancy)
);
